// File: sv/register_log_player_macros.svh
// assertion helpers for the checker of the log player
`ifndef REGISTER_LOG_PLAYER_MACROS_SVH
`define REGISTER_LOG_PLAYER_MACROS_SVH

// same-cycle implication, sampled on the rising clock, off during reset
`define RLP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on the rising clock, off during reset
`define RLP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/rlp_pkg.sv
`default_nettype none

package rlp_pkg;

	localparam int POS_W  = 12;
	localparam int LEN_W  = 13;
	localparam int WAIT_W = 15;
	localparam int WORD_W = 16;
	localparam int REG_W  = 7;
	localparam int VAL_W  = 8;
	localparam int CFG_W  = 13;

	localparam int DEFAULT_PROGRAM_DEPTH = 4096;
	localparam int DEFAULT_MAX_WRITES    = 63;

	localparam int SHADOW_DEPTH = 128;

	// register numbers that route to chip b
	localparam logic [REG_W-1:0] CHIP_B_BASE = 7'd64;
	localparam logic [REG_W-1:0] CHIP_B_END  = 7'd69;

	// bit 15 of a command word marks a wait word
	localparam int WAIT_BIT = 15;

	typedef enum logic [1:0] {
		OP_LOAD = 2'd0,
		OP_TICK = 2'd1,
		OP_READ = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		KIND_CHIP_A = 3'd0,
		KIND_CHIP_B = 3'd1,
		KIND_SHADOW = 3'd2,
		KIND_DONE   = 3'd3,
		KIND_READ   = 3'd4
	} kind_t;

	// configuration register indexes
	localparam logic CFG_LENGTH = 1'b0;
	localparam logic CFG_LOOP   = 1'b1;

	typedef struct packed {
		logic             en;
		logic [REG_W-1:0] addr;
		logic [VAL_W-1:0] data;
	} shadow_wr_t;

endpackage

`default_nettype wire

// File: sv/rlp_ram.sv
`default_nettype none

module rlp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] waddr,
	input  wire [WIDTH-1:0]         wdata,
	input  wire                     re,
	input  wire [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// File: sv/rlp_shadow.sv
`default_nettype none

module rlp_shadow import rlp_pkg::*; (
	input  wire              clk,
	input  wire              arst_n,
	input  shadow_wr_t       wr,
	input  wire              rd_en,
	input  wire [REG_W-1:0]  rd_addr,
	output logic [VAL_W-1:0] rd_data
);

	// one valid bit per entry, so never-written entries read as zero
	logic [SHADOW_DEPTH-1:0] valid_q;
	logic                    rd_valid_s1;
	logic [VAL_W-1:0]        ram_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			if (wr.en) begin
				valid_q[wr.addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_s1 <= valid_q[rd_addr];
			end
		end
	end

	rlp_ram #(
		.WIDTH(VAL_W),
		.DEPTH(SHADOW_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (wr.en),
		.waddr(wr.addr),
		.wdata(wr.data),
		.re   (rd_en),
		.raddr(rd_addr),
		.rdata(ram_rdata)
	);

	assign rd_data = rd_valid_s1 ? ram_rdata : '0;

endmodule

`default_nettype wire

// File: sv/register_log_player.sv
`default_nettype none

// register log player: replays a stored stream of 16-bit command words as
// register write transactions. start is taken when busy is low; results leave
// on strobe for exactly one cycle each and the receiver cannot stall them, so
// it must take every strobed transaction. a load returns nothing. a read
// returns one result via the shadow read register, then the result registers.
// a tick that fetches nothing (no program or a running wait) returns its done
// result the next cycle with busy staying low. a tick that fetches words is
// busy while fetching, plus the done state when it stops at the write limit
// right after a write; the program memory read port gives one word per cycle.
// write results come in fetch order, one per cycle but for zero waits, then
// the done result with last set. PROGRAM_DEPTH is taken as a power of two.
module register_log_player import rlp_pkg::*; #(
	parameter int PROGRAM_DEPTH = DEFAULT_PROGRAM_DEPTH,
	parameter int MAX_WRITES    = DEFAULT_MAX_WRITES
) (
	input  wire               clk,
	input  wire               arst_n,
	// item transactions
	input  wire               start,
	output logic              busy,
	input  wire [1:0]         op,
	input  wire [POS_W-1:0]   word_address,
	input  wire [WORD_W-1:0]  word_value,
	input  wire [REG_W-1:0]   reg_index,
	// configuration transactions
	input  wire               cfg_valid,
	output logic              cfg_ready,
	input  wire               cfg_index,
	input  wire [CFG_W-1:0]   cfg_data,
	// result transactions
	output logic              strobe,
	output logic [2:0]        kind,
	output logic [REG_W-1:0]  reg_number,
	output logic [VAL_W-1:0]  reg_value,
	output logic              overrun,
	output logic              last
);

	localparam int AW = $clog2(PROGRAM_DEPTH);
	// fetch count per tick is bounded at twice the memory depth
	localparam int FW = $clog2(2 * PROGRAM_DEPTH) + 1;
	localparam logic [FW-1:0] FETCH_LIMIT = FW'(2 * PROGRAM_DEPTH);
	localparam int WW = $clog2(MAX_WRITES + 1);
	localparam logic [WW:0] WRITE_LIMIT = (WW + 1)'(MAX_WRITES);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_READ = 4'b0010,
		ST_EXEC = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	state_t state_q, state_d;

	// configuration
	logic [LEN_W-1:0] length_q;
	logic [POS_W-1:0] loop_q;

	// playback state
	logic [POS_W-1:0]  position_q, position_d;
	logic [WAIT_W-1:0] wait_q, wait_d;
	logic [FW-1:0]     fetch_q, fetch_d;
	logic [WW-1:0]     writes_q, writes_d;
	logic [REG_W-1:0]  rd_reg_q, rd_reg_d;

	// result registers
	logic             strobe_q;
	kind_t            kind_q;
	logic [REG_W-1:0] reg_number_q;
	logic [VAL_W-1:0] reg_value_q;
	logic             overrun_q;
	logic             last_q;

	logic             out_set;
	kind_t            out_kind;
	logic [REG_W-1:0] out_reg;
	logic [VAL_W-1:0] out_val;
	logic             out_ovr;
	logic             out_last;

	// memory ports
	logic              pm_we;
	logic              pm_re;
	logic [WORD_W-1:0] pm_rdata;
	shadow_wr_t        sh_wr;
	logic              sh_re;
	logic [VAL_W-1:0]  sh_rdata;

	// position advance with wrap to the loop point
	logic [LEN_W-1:0] pos_inc;
	logic [POS_W-1:0] pos_next;

	// fetched word decode
	logic              word_is_wait;
	logic [WAIT_W-1:0] word_wait;
	logic [REG_W-1:0]  word_reg;
	logic [VAL_W-1:0]  word_val;
	logic [WW:0]       writes_after;
	logic              fetch_more;

	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;

	assign pos_inc  = LEN_W'(position_q) + LEN_W'(1);
	assign pos_next = (pos_inc >= length_q) ? loop_q : pos_inc[POS_W-1:0];

	assign word_is_wait = pm_rdata[WAIT_BIT];
	assign word_wait    = pm_rdata[WAIT_W-1:0];
	assign word_reg     = pm_rdata[VAL_W +: REG_W];
	assign word_val     = pm_rdata[VAL_W-1:0];
	assign writes_after = word_is_wait ? {1'b0, writes_q} : ({1'b0, writes_q} + 1'b1);
	assign fetch_more   = (writes_after < WRITE_LIMIT) && (fetch_q < FETCH_LIMIT);

	always_comb begin
		state_d    = state_q;
		position_d = position_q;
		wait_d     = wait_q;
		fetch_d    = fetch_q;
		writes_d   = writes_q;
		rd_reg_d   = rd_reg_q;
		pm_we      = 1'b0;
		pm_re      = 1'b0;
		sh_wr      = '{en: 1'b0, addr: word_reg, data: word_val};
		sh_re      = 1'b0;
		out_set    = 1'b0;
		out_kind   = KIND_DONE;
		out_reg    = '0;
		out_val    = '0;
		out_ovr    = 1'b0;
		out_last   = 1'b1;

		case (state_q)
			ST_IDLE: begin
				if (start) begin
					case (op)
						OP_LOAD: begin
							pm_we = 1'b1;
						end
						OP_TICK: begin
							if (length_q == '0) begin
								out_set = 1'b1;
							end else if (wait_q != '0) begin
								wait_d  = wait_q - 1'b1;
								out_set = 1'b1;
							end else begin
								// first fetch issues right away
								pm_re      = 1'b1;
								position_d = pos_next;
								fetch_d    = FW'(1);
								writes_d   = '0;
								state_d    = ST_EXEC;
							end
						end
						OP_READ: begin
							sh_re    = 1'b1;
							rd_reg_d = reg_index;
							state_d  = ST_READ;
						end
						default: begin
						end
					endcase
				end
			end
			ST_READ: begin
				out_set  = 1'b1;
				out_kind = KIND_READ;
				out_reg  = rd_reg_q;
				out_val  = sh_rdata;
				state_d  = ST_IDLE;
			end
			ST_EXEC: begin
				if (word_is_wait && word_wait != '0) begin
					// wait word ends the tick, counter already counts this tick
					wait_d  = word_wait - 1'b1;
					out_set = 1'b1;
					state_d = ST_IDLE;
				end else begin
					if (!word_is_wait) begin
						sh_wr.en = 1'b1;
						out_set  = 1'b1;
						out_last = 1'b0;
						out_val  = word_val;
						if (word_reg < CHIP_B_BASE) begin
							out_kind = KIND_CHIP_A;
							out_reg  = word_reg;
						end else if (word_reg < CHIP_B_END) begin
							out_kind = KIND_CHIP_B;
							out_reg  = word_reg - CHIP_B_BASE;
						end else begin
							out_kind = KIND_SHADOW;
							out_reg  = word_reg;
						end
					end
					writes_d = writes_after[WW-1:0];
					if (fetch_more) begin
						pm_re      = 1'b1;
						position_d = pos_next;
						fetch_d    = fetch_q + 1'b1;
					end else if (!word_is_wait) begin
						// limit hit right after a write: done goes out next cycle
						state_d = ST_DONE;
					end else begin
						// zero wait at the fetch limit
						out_set = 1'b1;
						out_ovr = 1'b1;
						state_d = ST_IDLE;
					end
				end
			end
			ST_DONE: begin
				out_set = 1'b1;
				out_ovr = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			length_q   <= '0;
			loop_q     <= '0;
			position_q <= '0;
			wait_q     <= '0;
			fetch_q    <= '0;
			writes_q   <= '0;
			strobe_q   <= 1'b0;
		end else begin
			state_q    <= state_d;
			position_q <= position_d;
			wait_q     <= wait_d;
			fetch_q    <= fetch_d;
			writes_q   <= writes_d;
			strobe_q   <= out_set;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_LENGTH: length_q <= cfg_data;
					CFG_LOOP:   loop_q   <= cfg_data[POS_W-1:0];
					default: begin
					end
				endcase
			end
		end
	end

	// result payload, no reset needed
	always_ff @(posedge clk) begin
		rd_reg_q <= rd_reg_d;
		if (out_set) begin
			kind_q       <= out_kind;
			reg_number_q <= out_reg;
			reg_value_q  <= out_val;
			overrun_q    <= out_ovr;
			last_q       <= out_last;
		end
	end

	rlp_ram #(
		.WIDTH(WORD_W),
		.DEPTH(PROGRAM_DEPTH)
	) u_program (
		.clk  (clk),
		.we   (pm_we),
		.waddr(AW'(word_address)),
		.wdata(word_value),
		.re   (pm_re),
		.raddr(AW'(position_q)),
		.rdata(pm_rdata)
	);

	rlp_shadow u_shadow (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (sh_wr),
		.rd_en  (sh_re),
		.rd_addr(reg_index),
		.rd_data(sh_rdata)
	);

	assign strobe     = strobe_q;
	assign kind       = kind_q;
	assign reg_number = reg_number_q;
	assign reg_value  = reg_value_q;
	assign overrun    = overrun_q;
	assign last       = last_q;

endmodule

`default_nettype wire

// File: sv/rlp_checker.sv
`default_nettype none

`include "register_log_player_macros.svh"

module rlp_checker import rlp_pkg::*; (
	input wire              clk,
	input wire              arst_n,
	input wire              start,
	input wire              busy,
	input wire [1:0]        op,
	input wire [POS_W-1:0]  word_address,
	input wire [WORD_W-1:0] word_value,
	input wire [REG_W-1:0]  reg_index,
	input wire              cfg_valid,
	input wire              cfg_ready,
	input wire              cfg_index,
	input wire [CFG_W-1:0]  cfg_data,
	input wire              strobe,
	input wire [2:0]        kind,
	input wire [REG_W-1:0]  reg_number,
	input wire [VAL_W-1:0]  reg_value,
	input wire              overrun,
	input wire              last
);

	// only done and read results close an item
	`RLP_ASSERT_NOW(a_last_kind, strobe && last, kind == KIND_DONE || kind == KIND_READ, "last on a write result")
	// write results never close an item and never flag overrun
	`RLP_ASSERT_NOW(a_write_kind, strobe && !last, (kind == KIND_CHIP_A || kind == KIND_CHIP_B || kind == KIND_SHADOW) && !overrun, "bad non-final result")
	// chip b register numbers stay inside its five registers
	`RLP_ASSERT_NOW(a_chip_b_range, strobe && kind == KIND_CHIP_B, reg_number < 7'd5, "chip b register out of range")
	// overrun appears only on a done result
	`RLP_ASSERT_NOW(a_overrun_done, strobe && overrun, kind == KIND_DONE && last, "overrun outside done")
	// a load transaction produces no result
	`RLP_ASSERT_NEXT(a_load_quiet, start && !busy && op == OP_LOAD, !strobe, "result after a load")

endmodule

bind register_log_player rlp_checker u_rlp_checker (.*);

`default_nettype wire

// File: test/tb_register_log_player.sv
`timescale 1ns / 1ps

module tb_register_log_player;
	import rlp_pkg::*;

	localparam int CLK_HALF    = 10;
	localparam int CYCLE_LIMIT = 600000;
	// a tick gives up after this many fetches with the wait counter at zero
	localparam int FETCH_LIMIT = 2 * DEFAULT_PROGRAM_DEPTH;
	// op code with no function, the block drops it
	localparam logic [1:0] OP_UNUSED = 2'd3;

	// one result transaction as the player should emit it
	typedef struct {
		kind_t            kind;
		logic [REG_W-1:0] reg_number;
		logic [VAL_W-1:0] reg_value;
		logic             overrun;
		logic             last_flag;
	} player_txn_t;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic [1:0]        op;
	logic [POS_W-1:0]  word_address;
	logic [WORD_W-1:0] word_value;
	logic [REG_W-1:0]  reg_index;
	logic              cfg_valid;
	logic              cfg_ready;
	logic              cfg_index;
	logic [CFG_W-1:0]  cfg_data;
	logic              strobe;
	logic [2:0]        kind;
	logic [REG_W-1:0]  reg_number;
	logic [VAL_W-1:0]  reg_value;
	logic              overrun;
	logic              last;

	// shadow copy of the player state
	logic [WORD_W-1:0] log_mem [DEFAULT_PROGRAM_DEPTH];
	logic [VAL_W-1:0]  shadow_mem [SHADOW_DEPTH];
	logic [POS_W-1:0]  play_pos;
	logic [WAIT_W-1:0] wait_left;
	logic [LEN_W-1:0]  stream_len;
	logic [POS_W-1:0]  loop_pos;

	// results still owed by the player, oldest first
	player_txn_t due_transactions [$];
	player_txn_t want_txn;

	// when set the sender never idles
	bit steady;

	int cycle_count;
	int mismatch_count;
	int result_count;
	int item_count, tick_count, read_count, load_count, cfg_count;
	int chip_a_count, chip_b_count, shadow_count, stopped_count;

	register_log_player dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.op           (op),
		.word_address (word_address),
		.word_value   (word_value),
		.reg_index    (reg_index),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.strobe       (strobe),
		.kind         (kind),
		.reg_number   (reg_number),
		.reg_value    (reg_value),
		.overrun      (overrun),
		.last         (last)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// watchdog on total run time
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still due", cycle_count,
				due_transactions.size());
			$display("simulation failed");
			$finish;
		end
	end

	function automatic void queue_result(input kind_t k, input logic [REG_W-1:0] r,
			input logic [VAL_W-1:0] v, input logic ovr, input logic fin);
		player_txn_t t;
		t.kind       = k;
		t.reg_number = r;
		t.reg_value  = v;
		t.overrun    = ovr;
		t.last_flag  = fin;
		due_transactions.push_back(t);
	endfunction

	// predictor: advance the shadow state by one accepted item and queue its results
	task automatic play_item(input logic [1:0] code, input logic [POS_W-1:0] addr,
			input logic [WORD_W-1:0] value, input logic [REG_W-1:0] idx);
		int                writes;
		int                fetches;
		logic              stopped;
		logic [WORD_W-1:0] w;
		logic [POS_W:0]    nxt;
		logic [REG_W-1:0]  target;
		if (code == OP_LOAD) begin
			log_mem[addr] = value;
		end else if (code == OP_READ) begin
			queue_result(KIND_READ, idx, shadow_mem[idx], 1'b0, 1'b1);
		end else if (code == OP_TICK) begin
			writes  = 0;
			fetches = 0;
			stopped = 1'b0;
			// no program: only the done transaction, state untouched
			if (stream_len != 0) begin
				while (wait_left == 0) begin
					// write limit or runaway chain of zero waits
					if (writes >= DEFAULT_MAX_WRITES || fetches >= FETCH_LIMIT) begin
						stopped = 1'b1;
						break;
					end
					w = log_mem[play_pos];
					fetches++;
					nxt = play_pos + 1'b1;
					// wrap to the loop point, also when it lies past the end
					if (nxt >= stream_len)
						nxt = loop_pos;
					play_pos = nxt[POS_W-1:0];
					if (w[WAIT_BIT]) begin
						wait_left = w[WAIT_W-1:0];
					end else begin
						target = w[WAIT_BIT-1:VAL_W];
						shadow_mem[target] = w[VAL_W-1:0];
						if (target < CHIP_B_BASE)
							queue_result(KIND_CHIP_A, target, w[VAL_W-1:0], 1'b0, 1'b0);
						else if (target < CHIP_B_END)
							queue_result(KIND_CHIP_B, target - CHIP_B_BASE, w[VAL_W-1:0],
								1'b0, 1'b0);
						else
							queue_result(KIND_SHADOW, target, w[VAL_W-1:0], 1'b0, 1'b0);
						writes++;
					end
				end
				// a stopped tick leaves the counter at zero so the next one resumes
				if (wait_left != 0)
					wait_left = wait_left - 1'b1;
			end
			queue_result(KIND_DONE, '0, '0, stopped, 1'b1);
		end
	endtask

	// offer one item transaction; idles at random before it unless steady
	task automatic send_item(input logic [1:0] code, input logic [POS_W-1:0] addr,
			input logic [WORD_W-1:0] value, input logic [REG_W-1:0] idx);
		while (!steady && $urandom_range(99) < 27) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start        <= 1'b1;
		op           <= code;
		word_address <= addr;
		word_value   <= value;
		reg_index    <= idx;
		// taken at the first edge with busy low
		do @(posedge clk); while (busy !== 1'b0);
		play_item(code, addr, value, idx);
		item_count++;
		if (code == OP_TICK)
			tick_count++;
		else if (code == OP_READ)
			read_count++;
		else if (code == OP_LOAD)
			load_count++;
	endtask

	// stop sending and let every owed result drain, then a few quiet cycles
	task automatic settle();
		start <= 1'b0;
		while (due_transactions.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// one configuration transaction; valid is left high for a following write
	task automatic put_setting(input logic which, input logic [CFG_W-1:0] value);
		while ($urandom_range(99) < 27) begin
			cfg_valid <= 1'b0;
			@(posedge clk);
		end
		cfg_valid <= 1'b1;
		cfg_index <= which;
		cfg_data  <= value;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		if (which == CFG_LENGTH)
			stream_len = value;
		else
			loop_pos = value[POS_W-1:0];
		cfg_count++;
	endtask

	// write both registers in random order, only while the player is idle
	task automatic configure(input logic [CFG_W-1:0] len, input logic [CFG_W-1:0] loop_at);
		if ($urandom_range(1)) begin
			put_setting(CFG_LENGTH, len);
			put_setting(CFG_LOOP, loop_at);
		end else begin
			put_setting(CFG_LOOP, loop_at);
			put_setting(CFG_LENGTH, len);
		end
		cfg_valid <= 1'b0;
	endtask

	// random command word: wait word with a short count or a register write
	function automatic logic [WORD_W-1:0] make_word(input int wait_pct, input int max_wait);
		logic [WORD_W-1:0] w;
		int                count;
		int                pick;
		logic [REG_W-1:0]  target;
		if ($urandom_range(99) < wait_pct) begin
			count = $urandom_range(max_wait);
			// zero waits should be common
			if ($urandom_range(1))
				count = count % 3;
			w = '0;
			w[WAIT_BIT] = 1'b1;
			w[WAIT_W-1:0] = count[WAIT_W-1:0];
		end else begin
			pick = $urandom_range(9);
			if (pick < 7)
				target = $urandom_range(SHADOW_DEPTH - 1);
			else
				target = $urandom_range(CHIP_B_END - 1, CHIP_B_BASE);
			w = {1'b0, target, 8'($urandom_range(255))};
		end
		return w;
	endfunction

	// fill every word the player can reach under the current settings:
	// the stream, the loop point and the word it sits on now
	task automatic load_reachable(input int wait_pct, input int max_wait);
		int a;
		for (a = 0; a < DEFAULT_PROGRAM_DEPTH; a++)
			if (a < stream_len || a == loop_pos || a == play_pos)
				send_item(OP_LOAD, a[POS_W-1:0], make_word(wait_pct, max_wait), '0);
	endtask

	// reset state: zero shadows, no program, ignored op, extreme load values
	task automatic test_after_reset();
		configure('0, '0);
		send_item(OP_READ, '0, '0, 7'd0);
		send_item(OP_READ, '0, '0, 7'd127);
		send_item(OP_TICK, '0, '0, '0);
		send_item(OP_UNUSED, '1, '1, '1);
		// parked here, overwritten before any tick can reach it
		send_item(OP_LOAD, 12'hfff, 16'hffff, '0);
		send_item(OP_LOAD, 12'h000, 16'h0000, '0);
		send_item(OP_TICK, '0, '0, '0);
	endtask

	// every routing bound, a zero wait, a real wait and the loop wrap
	task automatic test_routing();
		logic [WORD_W-1:0] words [8];
		int                i;
		words = '{16'h00ff, 16'h3f01, 16'h4080, 16'h4455,
			16'h45aa, 16'h8000, 16'h7f3c, 16'h8002};
		settle();
		configure(13'd8, 13'd2);
		for (i = 0; i < 8; i++)
			send_item(OP_LOAD, i[POS_W-1:0], words[i], '0);
		// whole stream, then a wait tick, then the looped part
		repeat (3) send_item(OP_TICK, '0, '0, '0);
		send_item(OP_READ, '0, '0, 7'd0);
		send_item(OP_READ, '0, '0, 7'd63);
		send_item(OP_READ, '0, '0, 7'd64);
		send_item(OP_READ, '0, '0, 7'd68);
		send_item(OP_READ, '0, '0, 7'd69);
		send_item(OP_READ, '0, '0, 7'd127);
		send_item(OP_READ, '0, '0, 7'd5);
	endtask

	// writes only: a tick stops after the write limit and the next resumes
	task automatic test_write_limit();
		settle();
		configure(13'd70, 13'd0);
		load_reachable(0, 0);
		repeat (4) send_item(OP_TICK, '0, '0, '0);
	endtask

	// zero waits only: a tick gives up after the fetch limit
	task automatic test_fetch_limit();
		settle();
		configure(13'd4, 13'd1);
		load_reachable(100, 0);
		repeat (2) send_item(OP_TICK, '0, '0, '0);
		send_item(OP_READ, '0, '0, $urandom_range(SHADOW_DEPTH - 1));
	endtask

	// loop point past the stream end: position parks on the loop point
	task automatic test_loop_past_end();
		settle();
		configure(13'd5, 13'd4095);
		load_reachable(30, 3);
		repeat (10) send_item(OP_TICK, '0, '0, '0);
		repeat (3) send_item(OP_READ, '0, '0, $urandom_range(SHADOW_DEPTH - 1));
	endtask

	// longest stream, loop at both ends of the memory
	task automatic test_full_program();
		settle();
		configure(13'd4096, 13'd4095);
		steady = 1'b1;
		load_reachable(15, 3);
		steady = 1'b0;
		repeat (12) send_item(OP_TICK, '0, '0, '0);
		settle();
		configure(13'd4096, 13'd0);
		repeat (12) send_item(OP_TICK, '0, '0, '0);
	endtask

	// random settings and programs, mostly ticks with reads and stray transactions
	task automatic test_random_phases();
		int phase, i, pick, len, loop_at, wait_pct, max_wait;
		for (phase = 0; phase < 6; phase++) begin
			settle();
			pick = $urandom_range(99);
			if (pick < 5)
				len = 0;
			else if (pick < 15)
				len = $urandom_range(4, 1);
			else if (pick < 80)
				len = $urandom_range(80, 5);
			else
				len = $urandom_range(700, 81);
			pick = $urandom_range(99);
			if (len > 0 && pick < 50)
				loop_at = $urandom_range(len - 1);
			else if (len > 0 && pick < 70)
				loop_at = len - 1;
			else
				loop_at = $urandom_range(DEFAULT_PROGRAM_DEPTH - 1);
			configure(len[CFG_W-1:0], loop_at[CFG_W-1:0]);
			wait_pct = $urandom_range(30, 5);
			max_wait = $urandom_range(12, 2);
			// first phase sends its items without random idle cycles
			steady = (phase == 0);
			load_reachable(wait_pct, max_wait);
			for (i = 0; i < 50; i++) begin
				// hold off until the player has caught up
				if (i == 25)
					settle();
				pick = $urandom_range(99);
				if (pick < 65)
					send_item(OP_TICK, $urandom_range(4095), $urandom_range(65535),
						$urandom_range(127));
				else if (pick < 80)
					send_item(OP_READ, $urandom_range(4095), $urandom_range(65535),
						$urandom_range(SHADOW_DEPTH - 1));
				else if (pick < 92)
					send_item(OP_LOAD, $urandom_range(DEFAULT_PROGRAM_DEPTH - 1),
						make_word(wait_pct, max_wait), $urandom_range(127));
				else
					send_item(OP_UNUSED, $urandom_range(4095), $urandom_range(65535),
						$urandom_range(127));
			end
		end
		steady = 1'b0;
	endtask

	// check every strobed transaction against the oldest one due
	always @(posedge clk) begin
		if (arst_n === 1'b1 && strobe === 1'b1) begin
			result_count++;
			if (due_transactions.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("result %0d with nothing due: kind %0d reg %0d value %02h ovr %0b last %0b",
						result_count, kind, reg_number, reg_value, overrun, last);
			end else begin
				want_txn = due_transactions.pop_front();
				if (kind !== want_txn.kind || reg_number !== want_txn.reg_number
						|| reg_value !== want_txn.reg_value || overrun !== want_txn.overrun
						|| last !== want_txn.last_flag) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("mismatch on result %0d at cycle %0d", result_count, cycle_count);
						$display("  expected kind %0d reg %0d value %02h ovr %0b last %0b",
							want_txn.kind, want_txn.reg_number, want_txn.reg_value,
							want_txn.overrun, want_txn.last_flag);
						$display("  actual   kind %0d reg %0d value %02h ovr %0b last %0b",
							kind, reg_number, reg_value, overrun, last);
					end
				end
				case (want_txn.kind)
					KIND_CHIP_A: chip_a_count++;
					KIND_CHIP_B: chip_b_count++;
					KIND_SHADOW: shadow_count++;
					KIND_DONE: begin
						if (want_txn.overrun)
							stopped_count++;
					end
					default: ;
				endcase
			end
		end
	end

	initial begin
		int i;
		// every input known from time zero, reset held
		arst_n       = 1'b0;
		start        = 1'b0;
		op           = OP_LOAD;
		word_address = '0;
		word_value   = '0;
		reg_index    = '0;
		cfg_valid    = 1'b0;
		cfg_index    = CFG_LENGTH;
		cfg_data     = '0;
		steady       = 1'b0;
		// predictor starts from the reset state
		for (i = 0; i < SHADOW_DEPTH; i++)
			shadow_mem[i] = '0;
		play_pos   = '0;
		wait_left  = '0;
		stream_len = '0;
		loop_pos   = '0;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_after_reset();
		test_routing();
		test_write_limit();
		test_fetch_limit();
		test_loop_past_end();
		test_full_program();
		test_random_phases();

		// drain, then leave room for any stray transaction
		settle();
		repeat (16) @(posedge clk);

		$display("covered %0d items (%0d ticks, %0d reads, %0d loads), %0d register writes",
			item_count, tick_count, read_count, load_count, cfg_count);
		$display("saw %0d results: %0d chip A, %0d chip B, %0d shadow only, %0d stopped ticks",
			result_count, chip_a_count, chip_b_count, shadow_count, stopped_count);
		if (mismatch_count == 0 && due_transactions.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("%0d mismatches", mismatch_count);
			$display("simulation failed");
		end
		$finish;
	end

endmodule

// File: register_log_player.f
+incdir+sv
sv/rlp_pkg.sv
sv/rlp_ram.sv
sv/rlp_shadow.sv
sv/register_log_player.sv
sv/rlp_checker.sv
test/tb_register_log_player.sv
